// ===== design/shs_pkg.sv =====
// Package for the half-step stepper sequencer: op and register codes,
// configuration and result structs, the half-step coil table and leg lookups.
// No dependencies.
package shs_pkg;

    // Item opcodes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_NORMAL = 2'd1;
    localparam logic [1:0] OP_ROUTE  = 2'd2;
    localparam logic [1:0] OP_STOP   = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_LEG_COUNT = 3'd0;
    localparam logic [2:0] REG_LEG0      = 3'd1;
    localparam logic [2:0] REG_LEG1      = 3'd2;
    localparam logic [2:0] REG_LEG2      = 3'd3;
    localparam logic [2:0] REG_LEG_DIRS  = 3'd4;

    // Route limits
    localparam logic [2:0] MAX_LEGS = 3'd3;

    // Register reset values
    localparam logic [1:0]  RST_LEG_COUNT = 2'd3;
    localparam logic [15:0] RST_LEG0      = 16'd200;
    localparam logic [15:0] RST_LEG1      = 16'd400;
    localparam logic [15:0] RST_LEG2      = 16'd200;
    localparam logic [2:0]  RST_LEG_DIRS  = 3'd2;

    typedef struct packed {
        logic [1:0]  leg_count;
        logic [15:0] leg0_steps;
        logic [15:0] leg1_steps;
        logic [15:0] leg2_steps;
        logic [2:0]  leg_directions;
    } cfg_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       running;
        logic       route_done;
    } res_t;

    // Eight-phase half-step coil pattern
    function automatic logic [3:0] half_step_coils(input logic [2:0] ph);
        logic [3:0] c;
        case (ph)
            3'd0:    c = 4'h1;
            3'd1:    c = 4'h3;
            3'd2:    c = 4'h2;
            3'd3:    c = 4'h6;
            3'd4:    c = 4'h4;
            3'd5:    c = 4'hc;
            3'd6:    c = 4'h8;
            3'd7:    c = 4'h9;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

    // Step count of a route leg; legs past the third have none
    function automatic logic [15:0] leg_steps_of(input cfg_t cfg, input logic [1:0] leg);
        logic [15:0] s;
        case (leg)
            2'd0:    s = cfg.leg0_steps;
            2'd1:    s = cfg.leg1_steps;
            2'd2:    s = cfg.leg2_steps;
            default: s = 16'd0;
        endcase
        return s;
    endfunction

    // Direction of a route leg; legs past the third run anticlockwise
    function automatic logic leg_dir_of(input cfg_t cfg, input logic [1:0] leg);
        logic d;
        case (leg)
            2'd0:    d = cfg.leg_directions[0];
            2'd1:    d = cfg.leg_directions[1];
            2'd2:    d = cfg.leg_directions[2];
            default: d = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== design/shs_core.sv =====
// Sequencer core: step divider, target and route counters, phase and coil state.
// Computes the result of the current item in one pass. Depends on shs_pkg.
module shs_core import shs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_fire,
    input  logic [1:0]  op,
    input  logic        direction,
    input  logic [15:0] step_target,
    input  logic [15:0] period,
    input  cfg_t        cfg,
    output res_t        res_next
);

    logic        active_reg,    active_next;
    logic        route_mode_reg, route_mode_next;
    logic [15:0] target_reg,    target_next;
    logic [15:0] done_reg,      done_next;
    logic [1:0]  leg_reg,       leg_next;
    logic        dir_reg,       dir_next;
    logic [2:0]  phase_reg,     phase_next;
    logic [15:0] tperiod_reg,   tperiod_next;
    logic [15:0] tcount_reg,    tcount_next;
    logic [3:0]  coil_reg,      coil_next;

    logic [15:0] tc_inc;
    logic [2:0]  limit;
    logic [1:0]  leg_inc;
    logic        fire;
    logic        advance;
    logic        adv_dir;
    logic        done_pulse;

    assign tc_inc  = tcount_reg + 16'd1;
    assign limit   = ({1'b0, cfg.leg_count} > MAX_LEGS) ? MAX_LEGS : {1'b0, cfg.leg_count};
    assign leg_inc = leg_reg + 2'd1;
    assign fire    = active_reg && (tc_inc >= tperiod_reg);

    // Next state for one item
    always_comb begin
        active_next     = active_reg;
        route_mode_next = route_mode_reg;
        target_next     = target_reg;
        done_next       = done_reg;
        leg_next        = leg_reg;
        dir_next        = dir_reg;
        phase_next      = phase_reg;
        tperiod_next    = tperiod_reg;
        tcount_next     = tcount_reg;
        coil_next       = coil_reg;
        advance         = 1'b0;
        adv_dir         = dir_reg;
        done_pulse      = 1'b0;

        case (op)
            OP_TICK: begin
                if (active_reg) begin
                    tcount_next = fire ? 16'd0 : tc_inc;
                end
                if (fire) begin
                    if (!route_mode_reg) begin
                        // Normal run: zero target means endless
                        if (target_reg == 16'd0) begin
                            advance = 1'b1;
                        end else if (done_reg < target_reg) begin
                            done_next = done_reg + 16'd1;
                            advance   = 1'b1;
                        end else begin
                            active_next = 1'b0;
                            coil_next   = 4'h0;
                        end
                    end else begin
                        // Route: finish leg, move to next leg, or end route
                        if (done_reg < target_reg) begin
                            done_next = done_reg + 16'd1;
                            advance   = 1'b1;
                        end else if ({1'b0, leg_reg} + 3'd1 < limit) begin
                            leg_next    = leg_inc;
                            done_next   = 16'd0;
                            target_next = leg_steps_of(cfg, leg_inc);
                            dir_next    = leg_dir_of(cfg, leg_inc);
                            adv_dir     = leg_dir_of(cfg, leg_inc);
                            advance     = 1'b1;
                        end else begin
                            active_next = 1'b0;
                            coil_next   = 4'h0;
                            done_pulse  = 1'b1;
                        end
                    end
                end
            end
            OP_NORMAL: begin
                dir_next        = direction;
                target_next     = step_target;
                done_next       = 16'd0;
                route_mode_next = 1'b0;
                tperiod_next    = (period == 16'd0) ? 16'd1 : period;
                tcount_next     = 16'd0;
                active_next     = 1'b1;
            end
            OP_ROUTE: begin
                route_mode_next = 1'b1;
                leg_next        = 2'd0;
                done_next       = 16'd0;
                target_next     = leg_steps_of(cfg, 2'd0);
                dir_next        = leg_dir_of(cfg, 2'd0);
                tperiod_next    = (period == 16'd0) ? 16'd1 : period;
                tcount_next     = 16'd0;
                active_next     = 1'b1;
            end
            default: begin
                active_next = 1'b0;
            end
        endcase

        // Phase step: up for anticlockwise, down for clockwise
        if (advance) begin
            phase_next = adv_dir ? (phase_reg - 3'd1) : (phase_reg + 3'd1);
            coil_next  = half_step_coils(phase_next);
        end
    end

    assign res_next = '{coils: coil_next, running: active_next, route_done: done_pulse};

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            route_mode_reg <= 1'b0;
            target_reg     <= 16'd0;
            done_reg       <= 16'd0;
            leg_reg        <= 2'd0;
            dir_reg        <= 1'b0;
            phase_reg      <= 3'd0;
            tperiod_reg    <= 16'd1;
            tcount_reg     <= 16'd0;
            coil_reg       <= 4'h0;
        end else if (item_fire) begin
            active_reg     <= active_next;
            route_mode_reg <= route_mode_next;
            target_reg     <= target_next;
            done_reg       <= done_next;
            leg_reg        <= leg_next;
            dir_reg        <= dir_next;
            phase_reg      <= phase_next;
            tperiod_reg    <= tperiod_next;
            tcount_reg     <= tcount_next;
            coil_reg       <= coil_next;
        end
    end

endmodule

// ===== design/stepper_half_step_sequencer_top.sv =====
// An accepted item's result is registered and shown on the m_ channel in the next cycle.
// Throughput: one item per cycle; the output register is reloaded in the same
// cycle its result is taken, so s_ready only drops while a result is stalled.
// Reset (aresetn low, synchronous): motor stopped, coils off, phase 0,
// route registers back to their defaults, no result pending.
// Top level: APB register file, sequencer core, output register. Uses shs_pkg.
module stepper_half_step_sequencer_top import shs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Item input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic        s_direction,
    input  logic [15:0] s_step_target,
    input  logic [15:0] s_period,
    // Result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_coils,
    output logic        m_running,
    output logic        m_route_done,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg;
    res_t       res_next;
    res_t       res_reg;
    logic       m_valid_reg;
    logic       item_fire;
    logic [2:0] reg_idx;

    assign reg_idx   = paddr[4:2];
    assign pready    = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign item_fire = s_valid && s_ready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leg_count      <= RST_LEG_COUNT;
            cfg_reg.leg0_steps     <= RST_LEG0;
            cfg_reg.leg1_steps     <= RST_LEG1;
            cfg_reg.leg2_steps     <= RST_LEG2;
            cfg_reg.leg_directions <= RST_LEG_DIRS;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_LEG_COUNT: cfg_reg.leg_count      <= pwdata[1:0];
                REG_LEG0:      cfg_reg.leg0_steps     <= pwdata[15:0];
                REG_LEG1:      cfg_reg.leg1_steps     <= pwdata[15:0];
                REG_LEG2:      cfg_reg.leg2_steps     <= pwdata[15:0];
                REG_LEG_DIRS:  cfg_reg.leg_directions <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_LEG_COUNT: prdata = {30'd0, cfg_reg.leg_count};
            REG_LEG0:      prdata = {16'd0, cfg_reg.leg0_steps};
            REG_LEG1:      prdata = {16'd0, cfg_reg.leg1_steps};
            REG_LEG2:      prdata = {16'd0, cfg_reg.leg2_steps};
            REG_LEG_DIRS:  prdata = {29'd0, cfg_reg.leg_directions};
            default:       prdata = 32'd0;
        endcase
    end

    shs_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_fire   (item_fire),
        .op          (s_op),
        .direction   (s_direction),
        .step_target (s_step_target),
        .period      (s_period),
        .cfg         (cfg_reg),
        .res_next    (res_next)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (item_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_coils      = res_reg.coils;
    assign m_running    = res_reg.running;
    assign m_route_done = res_reg.route_done;

`ifndef SYNTH
    // Route end always stops the timer and drops the coils
    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_route_done |-> !m_running && (m_coils == 4'h0))
        else $error("route_done with motor still driven");

    // A stop item leaves the timer idle
    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && (s_op == OP_STOP) |=> m_valid && !m_running && !m_route_done)
        else $error("stop item did not halt the timer");

    // A start item always arms the timer
    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && (s_op == OP_NORMAL || s_op == OP_ROUTE) |=> m_valid && m_running)
        else $error("start item did not arm the timer");

    // A taken result with nothing new behind it empties the output register
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !(s_valid && s_ready) |=> !m_valid)
        else $error("output register kept a taken result");
`endif

endmodule
